>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while out of reset
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Property checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> rtl/drtm_pkg.sv
package drtm_pkg;

  // Control byte bit positions
  localparam int unsigned CtlLowIe   = 0;
  localparam int unsigned CtlLowFl   = 1;
  localparam int unsigned CtlHighIe  = 2;
  localparam int unsigned CtlHighFl  = 3;
  localparam int unsigned CtlExt     = 4;
  localparam int unsigned CtlLong    = 5;
  localparam int unsigned CtlRunLow  = 6;
  localparam int unsigned CtlRunHigh = 7;

  // One machine tick as taken in
  typedef struct packed {
    logic [7:0] control;
    logic [7:0] reload_low;
    logic [7:0] reload_high;
    logic       prescale_tick;
    logic       pin_select;
    logic       pin_a_level;
    logic       pin_b_level;
  } tick_t;

  // One result beat
  typedef struct packed {
    logic [7:0] count_low;
    logic [7:0] count_high;
    logic [7:0] control_out;
    logic       low_irq;
    logic       high_irq;
  } result_t;

endpackage

>>> rtl/drtm_in_reg.sv
module drtm_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  drtm_pkg::tick_t tick_i,
  input  logic           down_ready_i,
  output logic           adv_o,
  output drtm_pkg::tick_t tick_o
);

  logic            valid_r;
  logic            valid_nxt;
  drtm_pkg::tick_t tick_r;

  // Stage moves on when the result register can take it
  assign adv_o    = valid_r && down_ready_i;
  assign in_stall = valid_r && !down_ready_i;
  assign tick_o   = tick_r;

  always_comb begin
    valid_nxt = valid_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload captured on each accepted beat
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      tick_r <= tick_i;
    end
  end

endmodule

>>> rtl/drtm_core.sv
module drtm_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv_i,
  input  drtm_pkg::tick_t   tick_i,
  output drtm_pkg::result_t res_o
);

  logic [7:0] low_r, low_nxt;
  logic [7:0] high_r, high_nxt;
  logic       low_run_r, low_run_nxt;
  logic       high_run_r, high_run_nxt;
  logic       last_pin_r, last_pin_nxt;

  logic       run_l, run_h, lng, ext, lvl, low_tick;
  logic [8:0] lo9, hi9, hi9_c;
  logic [7:0] ctl;
  logic       irq_l, irq_h;

  always_comb begin
    run_l = tick_i.control[drtm_pkg::CtlRunLow];
    run_h = tick_i.control[drtm_pkg::CtlRunHigh];
    lng   = tick_i.control[drtm_pkg::CtlLong];
    ext   = tick_i.control[drtm_pkg::CtlExt];
    ctl   = tick_i.control;
    irq_l = 1'b0;
    irq_h = 1'b0;

    // Low half clock source: prescaler or rising pin edge
    lvl          = tick_i.pin_select ? tick_i.pin_b_level : tick_i.pin_a_level;
    low_tick     = ext ? (lvl && !last_pin_r) : tick_i.prescale_tick;
    last_pin_nxt = ext ? lvl : last_pin_r;

    // Low half: load on start, count afterwards
    if (!run_l || !low_run_r) begin
      lo9 = {1'b0, tick_i.reload_low};
    end else if (low_tick) begin
      lo9 = {1'b0, low_r} + 9'd1;
    end else begin
      lo9 = {1'b0, low_r};
    end
    low_run_nxt = run_l;

    // High half: prescaler only in 8-bit mode
    if (!run_h || !high_run_r) begin
      hi9 = {1'b0, tick_i.reload_high};
    end else if (!lng && tick_i.prescale_tick) begin
      hi9 = {1'b0, high_r} + 9'd1;
    end else begin
      hi9 = {1'b0, high_r};
    end
    high_run_nxt = run_h;

    // Low overflow: flag in 8-bit mode, carry in long mode
    hi9_c = hi9;
    if (lo9[8]) begin
      if (!lng) begin
        ctl[drtm_pkg::CtlLowFl] = 1'b1;
        irq_l = ctl[drtm_pkg::CtlLowIe];
      end else if (run_h) begin
        hi9_c = hi9 + 9'd1;
      end
      low_nxt = tick_i.reload_low;
    end else begin
      low_nxt = lo9[7:0];
    end

    // High or 16-bit overflow
    if (hi9_c[8]) begin
      ctl[drtm_pkg::CtlHighFl] = 1'b1;
      if (lng) begin
        ctl[drtm_pkg::CtlLowFl] = 1'b1;
        low_nxt = tick_i.reload_low;
      end
      high_nxt = tick_i.reload_high;
      irq_h    = ctl[drtm_pkg::CtlHighIe];
    end else begin
      high_nxt = hi9_c[7:0];
    end

    res_o.count_low   = low_nxt;
    res_o.count_high  = high_nxt;
    res_o.control_out = ctl;
    res_o.low_irq     = irq_l;
    res_o.high_irq    = irq_h;
  end

  // Timer state, updated once per processed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r      <= '0;
      high_r     <= '0;
      low_run_r  <= 1'b0;
      high_run_r <= 1'b0;
      last_pin_r <= 1'b0;
    end else if (adv_i) begin
      low_r      <= low_nxt;
      high_r     <= high_nxt;
      low_run_r  <= low_run_nxt;
      high_run_r <= high_run_nxt;
      last_pin_r <= last_pin_nxt;
    end
  end

endmodule

>>> rtl/drtm_out_reg.sv
module drtm_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take_i,
  input  drtm_pkg::result_t res_i,
  output logic              ready_o,
  output logic              out_valid,
  input  logic              out_stall,
  output drtm_pkg::result_t res_o
);

  logic              valid_r;
  logic              valid_nxt;
  drtm_pkg::result_t res_r;

  // Free when empty or when the current beat leaves now
  assign ready_o   = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign res_o     = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take_i) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_i) begin
      res_r <= res_i;
    end
  end

endmodule

>>> rtl/dual_reload_timer_8_16_bit.sv
// Dual 8-bit reloadable timer, also usable as one 16-bit timer.
// Input channel: one beat per machine tick (control byte, two reload bytes,
// prescaler tick, pin select and both pin levels), valid/stall handshake.
// Result channel: one beat per input beat with both counts, the control
// byte with overflow flags set, and the two interrupt pulses.
// Path: a beat accepted into the input register moves, with the timer update,
// into the result register when that register can take it.
// Throughput: one beat per cycle while the receiver does not stall; the timer
// state loop is a single register update per tick.
// Reset (rst_n low, synchronous): both counts, run states and the pin edge
// history clear, and both pipeline registers empty.
// When the receiver stalls, the result register holds its beat; the input
// register can still take one more beat, after which in_stall rises until
// the result drains.
module dual_reload_timer_8_16_bit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_control,
  input  logic [7:0] in_reload_low,
  input  logic [7:0] in_reload_high,
  input  logic       in_prescale_tick,
  input  logic       in_pin_select,
  input  logic       in_pin_a_level,
  input  logic       in_pin_b_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_count_low,
  output logic [7:0] out_count_high,
  output logic [7:0] out_control_out,
  output logic       out_low_irq,
  output logic       out_high_irq
);

  drtm_pkg::tick_t   tick_in;
  drtm_pkg::tick_t   tick_s1;
  drtm_pkg::result_t res_c;
  drtm_pkg::result_t res_q;
  logic              adv;
  logic              down_ready;

  assign tick_in.control       = in_control;
  assign tick_in.reload_low    = in_reload_low;
  assign tick_in.reload_high   = in_reload_high;
  assign tick_in.prescale_tick = in_prescale_tick;
  assign tick_in.pin_select    = in_pin_select;
  assign tick_in.pin_a_level   = in_pin_a_level;
  assign tick_in.pin_b_level   = in_pin_b_level;

  drtm_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .tick_i       (tick_in),
    .down_ready_i (down_ready),
    .adv_o        (adv),
    .tick_o       (tick_s1)
  );

  drtm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv_i  (adv),
    .tick_i (tick_s1),
    .res_o  (res_c)
  );

  drtm_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .take_i    (adv),
    .res_i     (res_c),
    .ready_o   (down_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_o     (res_q)
  );

  assign out_count_low   = res_q.count_low;
  assign out_count_high  = res_q.count_high;
  assign out_control_out = res_q.control_out;
  assign out_low_irq     = res_q.low_irq;
  assign out_high_irq    = res_q.high_irq;

endmodule

>>> rtl/drtm_checker.sv
`include "assert_macros.svh"

module drtm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_control_out,
  input logic       out_low_irq,
  input logic       out_high_irq
);

  logic low_en_fl;
  logic high_en_fl;
  logic long_mode;

  // Enable and flag pairs as shown on the result control byte
  assign low_en_fl  = out_control_out[drtm_pkg::CtlLowIe] &&
                      out_control_out[drtm_pkg::CtlLowFl];
  assign high_en_fl = out_control_out[drtm_pkg::CtlHighIe] &&
                      out_control_out[drtm_pkg::CtlHighFl];
  assign long_mode  = out_control_out[drtm_pkg::CtlLong];

  // Low interrupt only with its enable and flag both set
  `ASSERT_RST(a_low_irq_flag, clk, rst_n, (out_valid && out_low_irq) |-> low_en_fl)

  // High interrupt only with its enable and flag both set
  `ASSERT_RST(a_high_irq_flag, clk, rst_n, (out_valid && out_high_irq) |-> high_en_fl)

  // Long mode never raises the low interrupt
  `ASSERT_RST(a_long_no_low_irq, clk, rst_n, (out_valid && out_low_irq) |-> !long_mode)

  // A stalled beat stays valid
  `ASSERT_RST(a_stall_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid)

  // Reset empties the result side
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind dual_reload_timer_8_16_bit drtm_checker u_drtm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_control_out (out_control_out),
  .out_low_irq     (out_low_irq),
  .out_high_irq    (out_high_irq)
);
